>>> rtl/vps_pkg.sv
package vps_pkg;

  // Resistor divider and standby idle limit
  localparam int unsigned PULLUP_OHMS   = 200000;
  localparam int unsigned PULLDOWN_OHMS = 20000;
  localparam int unsigned SLEEP_TICKS   = 10;

  // Full-scale code of the converter
  localparam int unsigned ADC_FULL = 4095;

  // Divider ratio split into whole part and remainder
  localparam int unsigned DIV_NUM = PULLUP_OHMS + PULLDOWN_OHMS;
  localparam int unsigned SCALE_Q = DIV_NUM / PULLDOWN_OHMS;
  localparam int unsigned SCALE_R = DIV_NUM % PULLDOWN_OHMS;

  // Datapath widths
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned PROD_W  = 2 * CODE_W;
  localparam int unsigned SCALE_W = 25;
  localparam int unsigned HI_W    = CODE_W + SCALE_W;
  localparam int unsigned SUM_W   = HI_W + 1;

  // Reciprocal of the pulldown for the remainder part; exact for every
  // 12-bit quotient as long as 2^RECIP_SH covers 4096 times the pulldown
  localparam int unsigned RECIP_SH = 36;
  localparam int unsigned RECIP_W  = 36;
  localparam longint unsigned RECIP_M =
    ((64'(SCALE_R) << RECIP_SH) + 64'(PULLDOWN_OHMS) - 64'd1) / 64'(PULLDOWN_OHMS);
  localparam int unsigned FRAC_W   = CODE_W + RECIP_W;

  // Input kind codes
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_KICK   = 2'd1;
  localparam logic [1:0] KIND_SERIAL = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_KICK,
    OP_SERIAL,
    OP_IGNORE
  } op_e;

  typedef enum logic [2:0] {
    MODE_STANDBY  = 3'd0,
    MODE_STARTING = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_SHUTDOWN = 3'd3,
    MODE_RESTART  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    CFG_ADC_REF    = 4'd0,
    CFG_UV_MV      = 4'd1,
    CFG_WAKE_MV    = 4'd2,
    CFG_WAKE_TICKS = 4'd3,
    CFG_START      = 4'd4,
    CFG_SHUTDOWN   = 4'd5,
    CFG_WDOG       = 4'd6,
    CFG_UV_TIMEOUT = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QUO,
    BK_SCALE,
    BK_SUM,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] adc_sample;
    logic        wake_level;
    logic        button_pressed;
  } vps_in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        router_enable;
    logic        converter_enable;
    logic        notify_pulse;
    logic        router_cycle_pulse;
    logic        sleep_request;
    logic [15:0] supply_mv;
  } vps_out_t;

  typedef struct packed {
    op_e         op;
    logic [11:0] adc_sample;
    logic        wake;
    logic        button;
  } vps_cmd_t;

  typedef struct packed {
    logic [11:0] adc_ref_mv;
    logic [15:0] uv_mv;
    logic [15:0] wake_mv;
    logic [15:0] wake_ticks;
    logic [15:0] start_ticks;
    logic [15:0] shut_ticks;
    logic [15:0] wdog_ticks;
    logic [15:0] uv_ticks;
  } vps_cfg_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

>>> rtl/vps_front.sv
module vps_front
  import vps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vps_in_t  in_data_i,
  output logic     push_o,
  input  logic     push_ready_i,
  output vps_cmd_t push_cmd_o
);

  logic     fr_valid_q, fr_valid_d;
  vps_cmd_t fr_q;
  vps_cmd_t cls;
  logic     accept;

  // Classify the request by kind
  always_comb begin
    cls.adc_sample = in_data_i.adc_sample;
    cls.wake       = in_data_i.wake_level;
    cls.button     = in_data_i.button_pressed;
    priority if (in_data_i.kind == KIND_TICK) begin
      cls.op = OP_TICK;
    end else if (in_data_i.kind == KIND_KICK) begin
      cls.op = OP_KICK;
    end else if (in_data_i.kind == KIND_SERIAL) begin
      cls.op = OP_SERIAL;
    end else begin
      cls.op = OP_IGNORE;
    end
  end

  // Hold one request until the queue takes it
  assign push_o     = fr_valid_q && push_ready_i;
  assign in_ready_o = !fr_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_cmd_o = fr_q;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_q <= cls;
    end
  end

endmodule

>>> rtl/vps_queue.sv
module vps_queue
  import vps_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  vps_cmd_t push_cmd_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  input  logic     pop_i,
  output vps_cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vps_cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push lost");

endmodule

>>> rtl/vps_back.sv
module vps_back
  import vps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  vps_cfg_t cfg_i,
  input  logic     q_valid_i,
  input  vps_cmd_t q_cmd_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vps_out_t out_data_o
);

  bk_state_e state_q, state_d;

  vps_cmd_t            cmd_q;
  logic [PROD_W-1:0]   prod_q;
  logic [CODE_W-1:0]   quo_q, quo_d;
  logic [HI_W-1:0]     hi_q;
  logic [FRAC_W-1:0]   frac_full;
  logic [CODE_W-1:0]   frac_q;
  logic [15:0]         mv_q, mv_sat;
  logic [SUM_W-1:0]    mv_full;
  logic [12:0]         part_sum, quo_wide;

  mode_e       mode_q, mode_d;
  logic [15:0] phase_q, phase_d;
  logic [15:0] low_q, low_d;
  logic [15:0] wdog_q, wdog_d;

  vps_out_t res_q, res_d;
  logic     res_valid_q, res_valid_d;

  logic exec_fire;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_cmd_i.op == OP_TICK) ? BK_QUO : BK_EXEC;
        end
      end
      BK_QUO:   state_d = BK_SCALE;
      BK_SCALE: state_d = BK_SUM;
      BK_SUM:   state_d = BK_EXEC;
      BK_EXEC:  state_d = exec_fire ? BK_IDLE : BK_EXEC;
      default:  state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o   = (state_q == BK_IDLE) && q_valid_i;
    exec_fire = (state_q == BK_EXEC) && (!res_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divide the raw product by full scale: x = 4095*a + (a + b)
  always_comb begin
    part_sum = 13'(prod_q[PROD_W-1:CODE_W]) + 13'(prod_q[CODE_W-1:0]);
    quo_wide = 13'(prod_q[PROD_W-1:CODE_W]);
    if (part_sum >= 13'(2 * ADC_FULL)) begin
      quo_wide = quo_wide + 13'd2;
    end else if (part_sum >= 13'(ADC_FULL)) begin
      quo_wide = quo_wide + 13'd1;
    end
    quo_d = quo_wide[CODE_W-1:0];
  end

  // Remainder part of the ratio through the pulldown reciprocal
  assign frac_full = FRAC_W'(quo_q) * FRAC_W'(RECIP_M);

  // Combine scaled parts and saturate
  assign mv_full = SUM_W'(hi_q) + SUM_W'(frac_q);
  assign mv_sat  = (mv_full > SUM_W'(16'hFFFF)) ? 16'hFFFF : mv_full[15:0];

  // Conversion datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q  <= q_cmd_i;
      prod_q <= PROD_W'(cfg_i.adc_ref_mv) * PROD_W'(q_cmd_i.adc_sample);
    end
    if (q_pop_o && (q_cmd_i.op != OP_TICK)) begin
      mv_q <= '0;
    end else if (state_q == BK_SUM) begin
      mv_q <= mv_sat;
    end
    if (state_q == BK_QUO) begin
      quo_q <= quo_d;
    end
    if (state_q == BK_SCALE) begin
      hi_q   <= HI_W'(quo_q) * HI_W'(SCALE_Q);
      frac_q <= frac_full[FRAC_W-1:RECIP_SH];
    end
  end

  // Mode machine update for one request
  always_comb begin
    logic [15:0] ph;
    logic [15:0] lo;
    logic [15:0] wd;
    logic        notify;
    logic        cycle;
    logic        sleep;
    mode_d  = mode_q;
    phase_d = phase_q;
    low_d   = low_q;
    wdog_d  = wdog_q;
    notify  = 1'b0;
    cycle   = 1'b0;
    sleep   = 1'b0;
    ph      = sat_inc(phase_q);
    lo      = sat_inc(low_q);
    wd      = sat_inc(wdog_q);
    unique case (cmd_q.op)
      OP_KICK: begin
        wdog_d = '0;
      end
      OP_SERIAL: begin
        if (mode_q == MODE_STANDBY) begin
          low_d = '0;
        end
      end
      OP_IGNORE: begin
      end
      OP_TICK: begin
        unique case (mode_q)
          MODE_STARTING, MODE_RESTART: begin
            if (ph >= cfg_i.start_ticks) begin
              mode_d  = MODE_RUNNING;
              phase_d = '0;
              wdog_d  = '0;
              low_d   = '0;
            end else begin
              phase_d = ph;
            end
          end
          MODE_RUNNING: begin
            if (!cmd_q.wake && (mv_q < cfg_i.uv_mv)) begin
              low_d = lo;
              if (lo > cfg_i.uv_ticks) begin
                mode_d  = MODE_SHUTDOWN;
                phase_d = '0;
                notify  = 1'b1;
              end
            end else begin
              low_d = '0;
            end
            if (!notify) begin
              if (cmd_q.button) begin
                wd = '0;
              end
              wdog_d = wd;
              if (wd > cfg_i.wdog_ticks) begin
                mode_d  = MODE_RESTART;
                phase_d = '0;
                cycle   = 1'b1;
              end
            end
          end
          MODE_SHUTDOWN: begin
            if (ph > cfg_i.shut_ticks) begin
              mode_d  = MODE_STANDBY;
              phase_d = '0;
              low_d   = '0;
            end else begin
              phase_d = ph;
            end
          end
          default: begin
            if (cmd_q.wake || (mv_q >= cfg_i.wake_mv)) begin
              low_d = '0;
              if (ph > cfg_i.wake_ticks) begin
                mode_d  = MODE_STARTING;
                phase_d = '0;
              end else begin
                phase_d = ph;
              end
            end else begin
              phase_d = '0;
              if (lo > 16'(SLEEP_TICKS)) begin
                sleep  = 1'b1;
                mode_d = MODE_STANDBY;
                low_d  = '0;
                wdog_d = '0;
              end else begin
                low_d = lo;
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase
    res_d.mode               = mode_d;
    res_d.router_enable      = (mode_d != MODE_STANDBY);
    res_d.converter_enable   = (mode_d != MODE_STANDBY);
    res_d.notify_pulse       = notify;
    res_d.router_cycle_pulse = cycle;
    res_d.sleep_request      = sleep;
    res_d.supply_mv          = mv_q;
  end

  // Hold the result until the receiver takes it
  always_comb begin
    res_valid_d = res_valid_q;
    if (exec_fire) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STANDBY;
      phase_q     <= '0;
      low_q       <= '0;
      wdog_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (exec_fire) begin
        mode_q  <= mode_d;
        phase_q <= phase_d;
        low_q   <= low_d;
        wdog_q  <= wdog_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  a_exec_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC && res_valid_q && !out_ready_i) |=> state_q == BK_EXEC)
    else $error("result overwritten while stalled");

  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == BK_IDLE && q_valid_i)
    else $error("pop outside idle");

  a_notify_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.notify_pulse) |-> res_q.mode == MODE_SHUTDOWN)
    else $error("notify without shutdown");

  a_sleep_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && res_d.sleep_request) |=> mode_q == MODE_STANDBY && phase_q == '0
      && low_q == '0 && wdog_q == '0)
    else $error("sleep did not clear state");

endmodule

>>> rtl/vehicle_power_sequencer.sv
// Vehicle power sequencer: a mode machine advanced by one-second tick requests.
// Input channel (in_valid_i/in_ready_o, in_data_i): tick, watchdog kick or
// serial activity requests. Each request yields exactly one result on the
// output channel (out_valid_o/out_ready_i, out_data_o) with mode, enables,
// one-shot pulses, sleep request and the converted supply in millivolts.
// Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// writes the eight thresholds; it is always ready, indexes past the list
// are dropped. Write it only while no request is in flight.
// A front register takes a request and hands it to a short queue; the
// back unit pops one request at a time. A tick runs pop, divide by full
// scale, scale, sum and update; kick and serial requests go from pop
// straight to update. The back unit pops the next request only after
// the update of the last one, which waits while the result is held.
// The result register holds while out_ready_i is low; the queue keeps
// filling and in_ready_o drops once front and queue are full.
// Reset puts the block in standby with all counters at zero and the
// configuration at its default values.
module vehicle_power_sequencer
  import vps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vps_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vps_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  vps_cfg_t cfg_q;
  vps_cmd_t push_cmd, pop_cmd;
  logic     push, push_ready, pop_valid, pop;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_ref_mv  <= 12'd3330;
      cfg_q.uv_mv       <= 16'd11800;
      cfg_q.wake_mv     <= 16'd13000;
      cfg_q.wake_ticks  <= 16'd2;
      cfg_q.start_ticks <= 16'd30;
      cfg_q.shut_ticks  <= 16'd30;
      cfg_q.wdog_ticks  <= 16'd60;
      cfg_q.uv_ticks    <= 16'd10;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ADC_REF:    cfg_q.adc_ref_mv  <= cfg_data_i[11:0];
        CFG_UV_MV:      cfg_q.uv_mv       <= cfg_data_i;
        CFG_WAKE_MV:    cfg_q.wake_mv     <= cfg_data_i;
        CFG_WAKE_TICKS: cfg_q.wake_ticks  <= cfg_data_i;
        CFG_START:      cfg_q.start_ticks <= cfg_data_i;
        CFG_SHUTDOWN:   cfg_q.shut_ticks  <= cfg_data_i;
        CFG_WDOG:       cfg_q.wdog_ticks  <= cfg_data_i;
        CFG_UV_TIMEOUT: cfg_q.uv_ticks    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  vps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  vps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (pop_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/vehicle_power_sequencer_test.sv
`timescale 1ns / 100ps

module vehicle_power_sequencer_test;
  import vps_pkg::*;

  localparam int RUN_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 225;
  localparam int FLOOD_ITEMS   = 24;

  // Input kind that the block answers without acting on it
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum int {DRIVE_WAKE, DRIVE_LOW, DRIVE_MIX} drive_e;
  typedef enum int {SET_DEFAULT, SET_FAST, SET_FLOOR, SET_CEILING, SET_RANDOM} profile_e;

  // Tracks the mode machine and holds the status words still due from the block
  class power_scoreboard;
    vps_cfg_t    regs;
    mode_e       mode_now;
    logic [15:0] phase_count;
    logic [15:0] low_count;
    logic [15:0] wdog_count;
    vps_out_t    expected_status[$];
    int          failures;

    function new();
      regs.adc_ref_mv  = 12'd3330;
      regs.uv_mv       = 16'd11800;
      regs.wake_mv     = 16'd13000;
      regs.wake_ticks  = 16'd2;
      regs.start_ticks = 16'd30;
      regs.shut_ticks  = 16'd30;
      regs.wdog_ticks  = 16'd60;
      regs.uv_ticks    = 16'd10;
      mode_now    = MODE_STANDBY;
      phase_count = '0;
      low_count   = '0;
      wdog_count  = '0;
      failures    = 0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void set_register(logic [3:0] idx, logic [15:0] data);
      case (idx)
        CFG_ADC_REF:    regs.adc_ref_mv  = data[11:0];
        CFG_UV_MV:      regs.uv_mv       = data;
        CFG_WAKE_MV:    regs.wake_mv     = data;
        CFG_WAKE_TICKS: regs.wake_ticks  = data;
        CFG_START:      regs.start_ticks = data;
        CFG_SHUTDOWN:   regs.shut_ticks  = data;
        CFG_WDOG:       regs.wdog_ticks  = data;
        CFG_UV_TIMEOUT: regs.uv_ticks    = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] count_up(logic [15:0] v);
      return (&v) ? v : v + 16'd1;
    endfunction

    // Divide by full scale first, then apply the divider ratio, truncating both
    function logic [15:0] supply_millivolts(logic [11:0] sample);
      longint unsigned v;
      v = regs.adc_ref_mv;
      v = v * sample / ADC_FULL;
      v = v * (PULLUP_OHMS + PULLDOWN_OHMS) / PULLDOWN_OHMS;
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void enter_mode(mode_e m);
      mode_now    = m;
      phase_count = '0;
      if (m == MODE_RUNNING) begin
        wdog_count = '0;
        low_count  = '0;
      end else if (m == MODE_STANDBY) begin
        low_count = '0;
      end
    endfunction

    function vps_out_t advance_mode(vps_in_t r);
      vps_out_t    o;
      logic [15:0] mv;
      logic        notify;
      logic        cycle;
      logic        sleep;
      logic        tripped;
      mv      = '0;
      notify  = 1'b0;
      cycle   = 1'b0;
      sleep   = 1'b0;
      tripped = 1'b0;
      case (r.kind)
        KIND_KICK: wdog_count = '0;
        KIND_SERIAL: if (mode_now == MODE_STANDBY) low_count = '0;
        KIND_TICK: begin
          mv = supply_millivolts(r.adc_sample);
          case (mode_now)
            MODE_STARTING, MODE_RESTART: begin
              phase_count = count_up(phase_count);
              if (phase_count >= regs.start_ticks) enter_mode(MODE_RUNNING);
            end
            MODE_RUNNING: begin
              // Low supply with ignition off takes priority over the watchdog
              if (!r.wake_level && mv < regs.uv_mv) begin
                low_count = count_up(low_count);
                if (low_count > regs.uv_ticks) begin
                  enter_mode(MODE_SHUTDOWN);
                  notify  = 1'b1;
                  tripped = 1'b1;
                end
              end else begin
                low_count = '0;
              end
              if (!tripped) begin
                wdog_count = count_up(wdog_count);
                if (r.button_pressed) wdog_count = '0;
                if (wdog_count > regs.wdog_ticks) begin
                  enter_mode(MODE_RESTART);
                  cycle = 1'b1;
                end
              end
            end
            MODE_SHUTDOWN: begin
              phase_count = count_up(phase_count);
              if (phase_count > regs.shut_ticks) enter_mode(MODE_STANDBY);
            end
            default: begin
              if (r.wake_level || mv >= regs.wake_mv) begin
                phase_count = count_up(phase_count);
                low_count   = '0;
                if (phase_count > regs.wake_ticks) enter_mode(MODE_STARTING);
              end else begin
                phase_count = '0;
                low_count   = count_up(low_count);
                // Idle timeout: request sleep and start over as after reset
                if (low_count > 16'(SLEEP_TICKS)) begin
                  sleep       = 1'b1;
                  mode_now    = MODE_STANDBY;
                  low_count   = '0;
                  wdog_count  = '0;
                end
              end
            end
          endcase
        end
        default: ;
      endcase
      o.mode               = mode_now;
      o.router_enable      = (mode_now != MODE_STANDBY);
      o.converter_enable   = (mode_now != MODE_STANDBY);
      o.notify_pulse       = notify;
      o.router_cycle_pulse = cycle;
      o.sleep_request      = sleep;
      o.supply_mv          = mv;
      return o;
    endfunction

    function void note_request(vps_in_t r);
      expected_status.push_back(advance_mode(r));
    endfunction

    function void check_result(vps_out_t got);
      vps_out_t want;
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected status word: mode %0d mv %0d", got.mode, got.supply_mv);
        return;
      end
      want = expected_status.pop_front();
      if (got.mode !== want.mode || got.router_enable !== want.router_enable ||
          got.converter_enable !== want.converter_enable ||
          got.notify_pulse !== want.notify_pulse ||
          got.router_cycle_pulse !== want.router_cycle_pulse ||
          got.sleep_request !== want.sleep_request || got.supply_mv !== want.supply_mv) begin
        failures++;
        if (failures <= 10)
          $display("status differs: expected mode %0d en %b/%b ntf %b cyc %b slp %b mv %0d, %s",
                   want.mode, want.router_enable, want.converter_enable, want.notify_pulse,
                   want.router_cycle_pulse, want.sleep_request, want.supply_mv,
                   $sformatf("got mode %0d en %b/%b ntf %b cyc %b slp %b mv %0d",
                             got.mode, got.router_enable, got.converter_enable,
                             got.notify_pulse, got.router_cycle_pulse, got.sleep_request,
                             got.supply_mv));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  vps_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  vps_out_t    out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  power_scoreboard sb = new();
  int idle_in_pct   = 0;
  int stall_pct     = 0;
  bit hold_results  = 1'b0;
  int cycle_count   = 0;

  vehicle_power_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", RUN_LIMIT);
      $display("vehicle_power_sequencer: mismatch");
      $finish;
    end
  end

  // Observe every handshake at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // Drive result ready: random stalls, or a long hold-off on demand
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_results = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic vps_in_t request(logic [1:0] kind, logic [11:0] sample,
                                      logic wake, logic button);
    vps_in_t r;
    r.kind           = kind;
    r.adc_sample     = sample;
    r.wake_level     = wake;
    r.button_pressed = button;
    return r;
  endfunction

  function automatic vps_in_t random_request(drive_e drive);
    vps_in_t r;
    int      roll;
    roll = $urandom_range(99);
    if (roll < 72)      r.kind = KIND_TICK;
    else if (roll < 82) r.kind = KIND_KICK;
    else if (roll < 92) r.kind = KIND_SERIAL;
    else                r.kind = KIND_SPARE;
    r.button_pressed = ($urandom_range(99) < 10);
    case (drive)
      DRIVE_WAKE: begin
        r.wake_level = ($urandom_range(99) < 70);
        r.adc_sample = 12'($urandom_range(4095, 1400));
      end
      DRIVE_LOW: begin
        r.wake_level = ($urandom_range(99) < 8);
        r.adc_sample = 12'($urandom_range(900, 0));
      end
      default: begin
        r.wake_level = 1'($urandom_range(1));
        r.adc_sample = 12'($urandom_range(4095));
      end
    endcase
    return r;
  endfunction

  function automatic vps_cfg_t settings_for(profile_e p);
    vps_cfg_t s;
    case (p)
      SET_FAST: begin
        s = '{adc_ref_mv: 12'($urandom_range(4000, 3000)), uv_mv: 16'd11800,
              wake_mv: 16'd13000, wake_ticks: 16'd1, start_ticks: 16'd2,
              shut_ticks: 16'd3, wdog_ticks: 16'd4, uv_ticks: 16'd2};
      end
      SET_FLOOR: begin
        s = '{adc_ref_mv: 12'd3000, uv_mv: 16'd7000, wake_mv: 16'd7001,
              wake_ticks: 16'd0, start_ticks: 16'd0, shut_ticks: 16'd0,
              wdog_ticks: 16'd0, uv_ticks: 16'd0};
      end
      SET_CEILING: begin
        s = '{adc_ref_mv: 12'd4095, uv_mv: 16'd40000, wake_mv: 16'd40000,
              wake_ticks: 16'hFFFF, start_ticks: 16'hFFFF, shut_ticks: 16'hFFFF,
              wdog_ticks: 16'hFFFF, uv_ticks: 16'hFFFF};
      end
      SET_RANDOM: begin
        s.adc_ref_mv  = ($urandom_range(99) < 20) ? 12'($urandom_range(4095))
                                                  : 12'($urandom_range(4000, 3000));
        s.uv_mv       = 16'($urandom_range(40000, 7000));
        s.wake_mv     = 16'($urandom_range(40000, 7001));
        s.wake_ticks  = 16'($urandom_range(8));
        s.start_ticks = 16'($urandom_range(8));
        s.shut_ticks  = 16'($urandom_range(8));
        s.wdog_ticks  = 16'($urandom_range(8));
        s.uv_ticks    = 16'($urandom_range(8));
      end
      default: begin
        s = '{adc_ref_mv: 12'd3330, uv_mv: 16'd11800, wake_mv: 16'd13000,
              wake_ticks: 16'd2, start_ticks: 16'd30, shut_ticks: 16'd30,
              wdog_ticks: 16'd60, uv_ticks: 16'd10};
      end
    endcase
    return s;
  endfunction

  // Offer one request, idling first at the sender's rate; valid stays high on return
  task automatic send_request(input vps_in_t r);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every status word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic put_register(input logic [3:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all thresholds plus one index past the list; the block must be idle
  task automatic program_settings(input vps_cfg_t s);
    put_register(CFG_ADC_REF, {4'($urandom), s.adc_ref_mv});
    put_register(CFG_UV_MV, s.uv_mv);
    put_register(CFG_WAKE_MV, s.wake_mv);
    put_register(CFG_WAKE_TICKS, s.wake_ticks);
    put_register(CFG_START, s.start_ticks);
    put_register(CFG_SHUTDOWN, s.shut_ticks);
    put_register(CFG_WDOG, s.wdog_ticks);
    put_register(CFG_UV_TIMEOUT, s.uv_ticks);
    put_register(4'($urandom_range(15, CFG_UV_TIMEOUT + 1)), 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Random requests in stretches that favor waking, low supply or a mix
  task automatic run_phase(input int count, input bit pause_midway);
    drive_e drive;
    int     remaining;
    remaining = 0;
    drive     = DRIVE_MIX;
    for (int n = 0; n < count; n++) begin
      if (remaining == 0) begin
        drive     = drive_e'($urandom_range(2));
        remaining = $urandom_range(60, 10);
      end
      remaining--;
      if (pause_midway && n == count / 2) wait_drained();
      send_request(random_request(drive));
    end
  endtask

  initial begin
    profile_e plan[8];
    plan = '{SET_FAST, SET_FLOOR, SET_RANDOM, SET_DEFAULT,
             SET_CEILING, SET_RANDOM, SET_RANDOM, SET_FAST};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: full-scale and zero samples, every kind, idle sleep, wake into starting
    send_request(request(KIND_TICK, 12'hFFF, 1'b0, 1'b0));
    send_request(request(KIND_SPARE, 12'hFFF, 1'b1, 1'b1));
    send_request(request(KIND_KICK, 12'h000, 1'b0, 1'b0));
    send_request(request(KIND_SERIAL, 12'h555, 1'b1, 1'b0));
    send_request(request(KIND_TICK, 12'h000, 1'b0, 1'b1));
    repeat (10) send_request(request(KIND_TICK, 12'h000, 1'b0, 1'b0));
    repeat (3) send_request(request(KIND_TICK, 12'h800, 1'b1, 1'b0));
    send_request(request(KIND_TICK, 12'hAAA, 1'b0, 1'b1));
    send_request(request(KIND_KICK, 12'hFFF, 1'b1, 1'b1));
    send_request(request(KIND_SERIAL, 12'h000, 1'b0, 1'b1));
    send_request(request(KIND_SPARE, 12'h000, 1'b0, 1'b0));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_in_pct = 0;  stall_pct = 0;  end
        1: begin idle_in_pct = 76; stall_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_pct = 76; end
        default: begin idle_in_pct = 13; stall_pct = 13; end
      endcase
      program_settings(settings_for(plan[p]));
      if (p == 2) begin
        // Hold results back while requests keep coming so the input stalls
        hold_results = 1'b1;
        repeat (FLOOD_ITEMS) send_request(random_request(DRIVE_MIX));
      end
      run_phase(PHASE_ITEMS, p == 5);
      wait_drained();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("vehicle_power_sequencer: match");
    end else begin
      $display("vehicle_power_sequencer: mismatch");
    end
    $finish;
  end

endmodule
